// File: hdl/rbm_pkg.sv
// rbm_pkg: shared constants, lane types and coefficient tables of the ripple
// bump-map texel pipeline. Used by the divider cell, the polynomial cell and by the top level.
// No dependencies.
package rbm_pkg;

	// default sizes, handed down to the top level parameters
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	// configuration port
	localparam int CFG_W      = 13;
	localparam int SCALE_W    = 8;
	localparam int CFG_ADDR_W = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_U_SCALE      = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_V_SCALE      = 2'd3;

	localparam logic [CFG_W-1:0]   WIDTH_RESET  = 13'd256;
	localparam logic [CFG_W-1:0]   HEIGHT_RESET = 13'd256;
	localparam logic [SCALE_W-1:0] SCALE_RESET  = 8'd1;

	// phase to turns and exponent scaling constants
	localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
	localparam logic [63:0] LOG2E_Q30      = 64'd1549082005;
	localparam logic [31:0] LN2_Q30        = 32'd744261118;

	// constant multipliers are split into two halves for the partial products
	localparam int MUL_W    = 38;
	localparam int MUL_LO_W = 19;
	localparam logic [MUL_W-1:0] MUL_A1  = MUL_W'(64'd300 * INV_TWO_PI_Q32);
	localparam logic [MUL_W-1:0] MUL_A2  = MUL_W'(64'd150 * INV_TWO_PI_Q32);
	localparam logic [MUL_W-1:0] MUL_A3  = MUL_W'(64'd140 * INV_TWO_PI_Q32);
	localparam logic [MUL_W-1:0] MUL_EXP = MUL_W'(64'd5 * LOG2E_Q30);

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

	// polynomial chain layout
	localparam int SIN_LANES      = 6;
	localparam int SIN_ORDER      = 4;
	localparam int SIN_FINAL_STEP = SIN_ORDER + 1;
	localparam int EXP_ORDER      = 7;
	localparam int POLY_STEPS     = 8;

	// one sine evaluation in flight
	typedef struct packed {
		logic [30:0] z;
		logic [30:0] x;
		logic [31:0] acc;
		logic        neg;
	} sin_lane_t;

	// the exponential in flight
	typedef struct packed {
		logic [29:0] w;
		logic [31:0] acc;
		logic [3:0]  n;
	} exp_lane_t;

	// odd sine polynomial, Q30
	function automatic logic [31:0] sin_coef(input int unsigned idx);
		logic [31:0] c;
		case (idx)
			0: c = 32'd1686629713;
			1: c = 32'd693598668;
			2: c = 32'd85569306;
			3: c = 32'd5026995;
			4: c = 32'd172272;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

	// Taylor series of exp(-w), Q30
	function automatic logic [31:0] exp_coef(input int unsigned idx);
		logic [31:0] c;
		case (idx)
			0: c = 32'd1073741824;
			1: c = 32'd1073741824;
			2: c = 32'd536870912;
			3: c = 32'd178956971;
			4: c = 32'd44739243;
			5: c = 32'd8947849;
			6: c = 32'd1491308;
			7: c = 32'd213044;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/ripple_bump_map_pixel.sv
// ripple_bump_map_pixel: top level of the ripple bump-map texel pipeline.
// Depends on rbm_pkg, rbm_div_cell, rbm_sqrt_cell and rbm_poly_cell.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid / s_tready  s_tdata = pixel_x, pixel_y
//   m_*       out   m_tvalid / m_tready  m_tdata = offset_u, offset_v
//   cfg_*     in    cfg_we               cfg_addr, cfg_data
//
// One texel per clock unless the output stalls; the pipeline is a
// row of FRAC_BITS divider cells, FRAC_BITS+1 square root cells and eight
// polynomial cells, plus plain stages around them.
// Reset clears the valid bits and loads the register defaults.
// The whole row moves whenever the output register is empty or taken, so
// a new transaction is taken while a result waits as long as it drains.
module ripple_bump_map_pixel #(
	parameter int COORD_BITS = rbm_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = rbm_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // pixel_x, pixel_y
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [15:0]                           m_tdata,  // offset_u, offset_v
	input  logic                                  cfg_we,
	input  logic [rbm_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [rbm_pkg::CFG_W-1:0]             cfg_data
);

	localparam int F   = FRAC_BITS;
	localparam int RB  = FRAC_BITS + 1;
	localparam int CW  = rbm_pkg::CFG_W;
	localparam int SSW = 2 * FRAC_BITS + 3;
	localparam int PW  = FRAC_BITS + rbm_pkg::MUL_W + 2;
	localparam int LW  = rbm_pkg::MUL_LO_W;
	localparam int HW  = rbm_pkg::MUL_W - rbm_pkg::MUL_LO_W;
	localparam int NL  = rbm_pkg::SIN_LANES;
	localparam logic [F-1:0] K085 = F'(((64'd85 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [3:0][rbm_pkg::MUL_W-1:0] MULS =
		{rbm_pkg::MUL_EXP, rbm_pkg::MUL_A3, rbm_pkg::MUL_A2, rbm_pkg::MUL_A1};
	localparam logic [4:0] TERM1_SHIFT = 5'd22;
	localparam logic [4:0] TERM2_SHIFT = 5'd9;
	localparam logic [4:0] TERM3_SHIFT = 5'd11;

	// truncate toward zero after a right shift, keep the low byte
	function automatic logic [7:0] trunc_byte(input logic signed [31:0] v,
	                                          input logic [4:0] sh);
		logic [31:0] mag;
		logic [31:0] q;
		mag = v[31] ? 32'(-v) : 32'(v);
		q   = mag >> sh;
		return v[31] ? 8'(-q) : 8'(q);
	endfunction

	logic en;

	// configuration registers
	logic [CW-1:0]              width_q;
	logic [CW-1:0]              height_q;
	logic [rbm_pkg::SCALE_W-1:0] u_scale_q;
	logic [rbm_pkg::SCALE_W-1:0] v_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= rbm_pkg::WIDTH_RESET;
			height_q  <= rbm_pkg::HEIGHT_RESET;
			u_scale_q <= rbm_pkg::SCALE_RESET;
			v_scale_q <= rbm_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				rbm_pkg::REG_IMAGE_WIDTH:  width_q   <= cfg_data;
				rbm_pkg::REG_IMAGE_HEIGHT: height_q  <= cfg_data;
				rbm_pkg::REG_U_SCALE:      u_scale_q <= cfg_data[rbm_pkg::SCALE_W-1:0];
				rbm_pkg::REG_V_SCALE:      v_scale_q <= cfg_data[rbm_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control: everything advances when the output slot frees up
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// input transaction register
	logic                  vld_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= s_tdata[COORD_BITS-1:0];
			y_s1 <= s_tdata[2*COORD_BITS-1:COORD_BITS];
		end
	end

	// divider setup: saturate when the coordinate is not below the divisor
	logic [1:0]          sat0;
	logic [1:0]          zero0;
	logic [1:0][CW-1:0]  divs;
	logic [1:0][CW-1:0]  rem0;

	always_comb begin
		divs[0]  = width_q;
		divs[1]  = height_q;
		sat0[0]  = 32'(x_s1) >= 32'(width_q);
		sat0[1]  = 32'(y_s1) >= 32'(height_q);
		zero0[0] = width_q == '0;
		zero0[1] = height_q == '0;
		rem0[0]  = sat0[0] ? '0 : CW'(x_s1);
		rem0[1]  = sat0[1] ? '0 : CW'(y_s1);
	end

	// divider row
	logic              dv_c   [F+1];
	logic [1:0][CW-1:0] drem_c [F+1];
	logic [1:0][F-1:0]  dquo_c [F+1];
	logic [3:0]         dside_c[F+1];

	assign dv_c[0]    = vld_s1;
	assign drem_c[0]  = rem0;
	assign dquo_c[0]  = '0;
	assign dside_c[0] = {zero0, sat0};

	for (genvar k = 0; k < F; k++) begin : g_div
		rbm_div_cell #(.QW(F), .SW(4)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv_c[k]),
			.divisor   (divs),
			.rem_in    (drem_c[k]),
			.quo_in    (dquo_c[k]),
			.side_in   (dside_c[k]),
			.out_valid (dv_c[k+1]),
			.rem_out   (drem_c[k+1]),
			.quo_out   (dquo_c[k+1]),
			.side_out  (dside_c[k+1])
		);
	end

	// normalized coordinates
	logic         vld_s2;
	logic [F-1:0] fx_s2;
	logic [F-1:0] fy_s2;
	logic [F-1:0] fx_nx;
	logic [F-1:0] fy_nx;

	always_comb begin
		fx_nx = dside_c[F][2] ? '0 : (dside_c[F][0] ? '1 : dquo_c[F][0]);
		fy_nx = dside_c[F][3] ? '0 : (dside_c[F][1] ? '1 : dquo_c[F][1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= dv_c[F];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s2 <= fx_nx;
			fy_s2 <= fy_nx;
		end
	end

	// radicand, coordinate sum and the 0.85*fx - fy difference
	logic            vld_s3;
	logic [2*RB-1:0] rad_s3;
	logic [F:0]      sum_s3;
	logic [F+1:0]    diff_s3;
	logic [2*F-1:0]  gprod;

	assign gprod = {{F{1'b0}}, fx_s2} * {{F{1'b0}}, K085};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3  <= (2*RB)'({{F{1'b0}}, fx_s2} * {{F{1'b0}}, fx_s2})
			         + (2*RB)'({{F{1'b0}}, fy_s2} * {{F{1'b0}}, fy_s2});
			sum_s3  <= {1'b0, fx_s2} + {1'b0, fy_s2};
			diff_s3 <= {2'b00, gprod[2*F-1:F]} - {2'b00, fy_s2};
		end
	end

	// square root row
	logic            sv_c   [RB+1];
	logic [2*RB-1:0] srad_c [RB+1];
	logic [RB+1:0]   srem_c [RB+1];
	logic [RB-1:0]   sroot_c[RB+1];
	logic [SSW-1:0]  sside_c[RB+1];

	assign sv_c[0]    = vld_s3;
	assign srad_c[0]  = rad_s3;
	assign srem_c[0]  = '0;
	assign sroot_c[0] = '0;
	assign sside_c[0] = {sum_s3, diff_s3};

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		rbm_sqrt_cell #(.RB(RB), .SW(SSW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sv_c[k]),
			.rad_in    (srad_c[k]),
			.rem_in    (srem_c[k]),
			.root_in   (sroot_c[k]),
			.side_in   (sside_c[k]),
			.out_valid (sv_c[k+1]),
			.rad_out   (srad_c[k+1]),
			.rem_out   (srem_c[k+1]),
			.root_out  (sroot_c[k+1]),
			.side_out  (sside_c[k+1])
		);
	end

	// partial products of the phase and exponent constant multiplies
	logic [F+1:0]       diff_r;
	logic               dneg;
	logic [3:0][F:0]    mag;
	logic               vld_s4;
	logic               dneg_s4;
	logic [3:0][F+LW:0] pl_s4;
	logic [3:0][F+HW:0] ph_s4;

	always_comb begin
		diff_r = sside_c[RB][F+1:0];
		dneg   = diff_r[F+1];
		mag[0] = sroot_c[RB];
		mag[1] = sside_c[RB][SSW-1:F+2];
		mag[2] = dneg ? (F+1)'(-diff_r) : (F+1)'(diff_r);
		mag[3] = sroot_c[RB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sv_c[RB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s4 <= dneg;
			for (int k = 0; k < 4; k++) begin
				pl_s4[k] <= (F+LW+1)'(mag[k]) * (F+LW+1)'(MULS[k][LW-1:0]);
				ph_s4[k] <= (F+HW+1)'(mag[k]) * (F+HW+1)'(MULS[k][rbm_pkg::MUL_W-1:LW]);
			end
		end
	end

	// angles in turns and the exponent split
	logic [3:0][PW-1:0] full;
	logic               vld_s5;
	logic [2:0][31:0]   ang_s5;
	logic [29:0]        frac_s5;
	logic [3:0]         n_s5;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			full[k] = PW'(pl_s4[k]) + (PW'(ph_s4[k]) << LW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s5[0] <= full[0][F+31:F];
			ang_s5[1] <= full[1][F+31:F];
			ang_s5[2] <= dneg_s4 ? 32'd0 - full[2][F+31:F] : full[2][F+31:F];
			frac_s5   <= full[3][F+29:F];
			n_s5      <= full[3][F+33:F+30];
		end
	end

	// lane setup: cosine is sine a quarter turn on, then quadrant folding
	rbm_pkg::sin_lane_t [NL-1:0] lane0;
	rbm_pkg::exp_lane_t          elane0;
	logic [31:0]                 lang [NL];

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			lang[i]      = (i % 2 == 0) ? ang_s5[i/2] + rbm_pkg::QUARTER_TURN : ang_s5[i/2];
			lane0[i].z   = lang[i][30] ? rbm_pkg::Q30_ONE - {1'b0, lang[i][29:0]}
			                           : {1'b0, lang[i][29:0]};
			lane0[i].x   = '0;
			lane0[i].acc = rbm_pkg::sin_coef(rbm_pkg::SIN_ORDER);
			lane0[i].neg = lang[i][31];
		end
		elane0.w   = frac_s5;
		elane0.acc = rbm_pkg::exp_coef(rbm_pkg::EXP_ORDER);
		elane0.n   = n_s5;
	end

	// polynomial row
	logic                        pv_c  [rbm_pkg::POLY_STEPS+1];
	rbm_pkg::sin_lane_t [NL-1:0] psin_c[rbm_pkg::POLY_STEPS+1];
	rbm_pkg::exp_lane_t          pexp_c[rbm_pkg::POLY_STEPS+1];

	assign pv_c[0]   = vld_s5;
	assign psin_c[0] = lane0;
	assign pexp_c[0] = elane0;

	for (genvar k = 0; k < rbm_pkg::POLY_STEPS; k++) begin : g_poly
		rbm_poly_cell #(.STEP(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (pv_c[k]),
			.sin_in    (psin_c[k]),
			.exp_in    (pexp_c[k]),
			.out_valid (pv_c[k+1]),
			.sin_out   (psin_c[k+1]),
			.exp_out   (pexp_c[k+1])
		);
	end

	// round to Q1.14, cap, apply sign; scale the exponential
	logic [32:0]               rsum [NL];
	logic [16:0]               rmag [NL];
	logic [NL-1:0][15:0]       trig_nx;
	logic [32:0]               esum;
	logic [32:0]               eshift;
	logic                      vld_s6;
	logic [NL-1:0][15:0]       trig_s6;
	logic [14:0]               ex_s6;

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			rsum[i]    = {1'b0, psin_c[rbm_pkg::POLY_STEPS][i].acc} + 33'd32768;
			rmag[i]    = rsum[i][32:16];
			if (rmag[i] > 17'd16384) begin
				rmag[i] = 17'd16384;
			end
			trig_nx[i] = psin_c[rbm_pkg::POLY_STEPS][i].neg ? 16'd0 - 16'(rmag[i])
			                                                : 16'(rmag[i]);
		end
		esum   = {1'b0, pexp_c[rbm_pkg::POLY_STEPS].acc}
		       + (33'd1 << (5'd15 + 5'(pexp_c[rbm_pkg::POLY_STEPS].n)));
		eshift = esum >> (5'd16 + 5'(pexp_c[rbm_pkg::POLY_STEPS].n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= pv_c[rbm_pkg::POLY_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s6 <= trig_nx;
			ex_s6   <= eshift[14:0];
		end
	end

	// damped ripple products and the two plain terms
	logic               vld_s7;
	logic signed [31:0] pu_s7;
	logic signed [31:0] pv_s7;
	logic [1:0][7:0]    t2_s7;
	logic [1:0][7:0]    t3_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s7    <= $signed(trig_s6[0]) * $signed({1'b0, ex_s6});
			pv_s7    <= $signed(trig_s6[1]) * $signed({1'b0, ex_s6});
			t2_s7[0] <= trunc_byte(32'(signed'(trig_s6[2])), TERM2_SHIFT);
			t2_s7[1] <= trunc_byte(32'(signed'(trig_s6[3])), TERM2_SHIFT);
			t3_s7[0] <= trunc_byte(32'(signed'(trig_s6[4])), TERM3_SHIFT);
			t3_s7[1] <= trunc_byte(32'(signed'(trig_s6[5])), TERM3_SHIFT);
		end
	end

	// byte sums, wrapping
	logic       vld_s8;
	logic [7:0] du_s8;
	logic [7:0] dv_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			du_s8 <= trunc_byte(pu_s7, TERM1_SHIFT) + t2_s7[0] + t3_s7[0];
			dv_s8 <= trunc_byte(pv_s7, TERM1_SHIFT) + t2_s7[1] + t3_s7[1];
		end
	end

	// scaling and the output register
	logic [15:0] su;
	logic [15:0] sv;
	logic [15:0] out_q;

	assign su = {8'd0, u_scale_q} * {8'd0, du_s8};
	assign sv = {8'd0, v_scale_q} * {8'd0, dv_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= {sv[7:0], su[7:0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// File: hdl/rbm_div_cell.sv
// rbm_div_cell: one restoring division step for the x and y lanes, one
// quotient bit per cell. Depends on rbm_pkg.
module rbm_div_cell #(
	parameter int QW = 16,
	parameter int SW = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [1:0][rbm_pkg::CFG_W-1:0]      divisor,
	input  logic [1:0][rbm_pkg::CFG_W-1:0]      rem_in,
	input  logic [1:0][QW-1:0]                  quo_in,
	input  logic [SW-1:0]                       side_in,
	output logic                                out_valid,
	output logic [1:0][rbm_pkg::CFG_W-1:0]      rem_out,
	output logic [1:0][QW-1:0]                  quo_out,
	output logic [SW-1:0]                       side_out
);

	logic [1:0][rbm_pkg::CFG_W:0]   trial;
	logic [1:0]                     ge;
	logic [1:0][rbm_pkg::CFG_W-1:0] rem_nx;
	logic [1:0][QW-1:0]             quo_nx;
	logic                           valid_q;
	logic [1:0][rbm_pkg::CFG_W-1:0] rem_q;
	logic [1:0][QW-1:0]             quo_q;
	logic [SW-1:0]                  side_q;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial[i]  = {rem_in[i], 1'b0};
			ge[i]     = trial[i] >= {1'b0, divisor[i]};
			rem_nx[i] = ge[i] ? rbm_pkg::CFG_W'(trial[i] - {1'b0, divisor[i]})
			                  : rbm_pkg::CFG_W'(trial[i]);
			quo_nx[i] = {quo_in[i][QW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_nx;
			quo_q  <= quo_nx;
			side_q <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_out   = rem_q;
	assign quo_out   = quo_q;
	assign side_out  = side_q;

endmodule

// File: hdl/rbm_sqrt_cell.sv
// rbm_sqrt_cell: one digit-by-digit integer square root step, one root bit
// per cell. No dependencies.
module rbm_sqrt_cell #(
	parameter int RB = 17,
	parameter int SW = 35
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RB-1:0] rad_in,
	input  logic [RB+1:0]   rem_in,
	input  logic [RB-1:0]   root_in,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [2*RB-1:0] rad_out,
	output logic [RB+1:0]   rem_out,
	output logic [RB-1:0]   root_out,
	output logic [SW-1:0]   side_out
);

	logic [RB+3:0]   rem_sh;
	logic [RB+3:0]   trial;
	logic            ge;
	logic [RB+1:0]   rem_nx;
	logic [RB-1:0]   root_nx;
	logic            valid_q;
	logic [2*RB-1:0] rad_q;
	logic [RB+1:0]   rem_q;
	logic [RB-1:0]   root_q;
	logic [SW-1:0]   side_q;

	// bring down two radicand bits and try 4*root+1
	always_comb begin
		rem_sh  = {rem_in, rad_in[2*RB-1:2*RB-2]};
		trial   = {2'b00, root_in, 2'b01};
		ge      = rem_sh >= trial;
		rem_nx  = ge ? (RB+2)'(rem_sh - trial) : (RB+2)'(rem_sh);
		root_nx = {root_in[RB-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_in[2*RB-3:0], 2'b00};
			rem_q  <= rem_nx;
			root_q <= root_nx;
			side_q <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign rad_out   = rad_q;
	assign rem_out   = rem_q;
	assign root_out  = root_q;
	assign side_out  = side_q;

endmodule

// File: hdl/rbm_poly_cell.sv
// rbm_poly_cell: one multiply step of the six sine polynomials and of the
// exponential series, selected by STEP. Depends on rbm_pkg.
module rbm_poly_cell #(
	parameter int STEP = 0
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            en,
	input  logic                                            in_valid,
	input  rbm_pkg::sin_lane_t [rbm_pkg::SIN_LANES-1:0]     sin_in,
	input  rbm_pkg::exp_lane_t                              exp_in,
	output logic                                            out_valid,
	output rbm_pkg::sin_lane_t [rbm_pkg::SIN_LANES-1:0]     sin_out,
	output rbm_pkg::exp_lane_t                              exp_out
);

	logic [31:0] sa [rbm_pkg::SIN_LANES];
	logic [31:0] sb [rbm_pkg::SIN_LANES];
	logic [63:0] sp [rbm_pkg::SIN_LANES];
	logic [31:0] ea;
	logic [31:0] eb;
	logic [63:0] ep;
	rbm_pkg::sin_lane_t [rbm_pkg::SIN_LANES-1:0] sin_nx;
	rbm_pkg::exp_lane_t                          exp_nx;
	logic                                        valid_q;
	rbm_pkg::sin_lane_t [rbm_pkg::SIN_LANES-1:0] sin_q;
	rbm_pkg::exp_lane_t                          exp_q;

	// sine lanes: square, Horner steps, then the final multiply by z
	always_comb begin
		sin_nx = sin_in;
		for (int i = 0; i < rbm_pkg::SIN_LANES; i++) begin
			sa[i] = (STEP == 0 || STEP == rbm_pkg::SIN_FINAL_STEP) ? {1'b0, sin_in[i].z}
			                                                       : {1'b0, sin_in[i].x};
			sb[i] = (STEP == 0) ? {1'b0, sin_in[i].z} : sin_in[i].acc;
			sp[i] = {32'd0, sa[i]} * {32'd0, sb[i]};
			if (STEP == 0) begin
				sin_nx[i].x = sp[i][60:30];
			end else if (STEP >= 1 && STEP <= rbm_pkg::SIN_ORDER) begin
				sin_nx[i].acc = rbm_pkg::sin_coef(rbm_pkg::SIN_ORDER - STEP) - sp[i][61:30];
			end else if (STEP == rbm_pkg::SIN_FINAL_STEP) begin
				sin_nx[i].acc = sp[i][61:30];
			end
		end
	end

	// exponential lane: w = frac * ln2, then Horner steps
	always_comb begin
		exp_nx = exp_in;
		ea     = {2'b00, exp_in.w};
		eb     = (STEP == 0) ? rbm_pkg::LN2_Q30 : exp_in.acc;
		ep     = {32'd0, ea} * {32'd0, eb};
		if (STEP == 0) begin
			exp_nx.w = ep[59:30];
		end else begin
			exp_nx.acc = rbm_pkg::exp_coef(rbm_pkg::EXP_ORDER - STEP) - ep[61:30];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= sin_nx;
			exp_q <= exp_nx;
		end
	end

	assign out_valid = valid_q;
	assign sin_out   = sin_q;
	assign exp_out   = exp_q;

endmodule
